// ===== hdl/ocsc_pkg.sv =====
package ocsc_pkg;

   // Filter structure
   localparam int FILTER_ORDER = 3;
   localparam int RATE_LOG2    = 2;
   localparam int SUB_COUNT    = 1 << RATE_LOG2;

   // Data widths
   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 32;
   localparam int MAG_W    = 15;

   // Scaling shifts around the clipper and at the output
   localparam int CLIP_SHIFT = (FILTER_ORDER - 1) * RATE_LOG2;
   localparam int OUT_SHIFT  = FILTER_ORDER * RATE_LOG2;

   // Clipper curve
   localparam int CLIP_KNEE_LO    = 10922;
   localparam int CLIP_KNEE_HI    = 21845;
   localparam int CLIP_OFFSET     = 10921;
   localparam int CLIP_SCALE_LOG2 = 15;
   localparam int CLIP_MAX        = 32767;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      REGION_LOW,
      REGION_MID,
      REGION_SAT
   } clip_region_type;

   // One low-rate value travelling between front, queue and back
   typedef struct packed {
      logic             valid;
      logic [ACC_W-1:0] data;
   } sample_type;

   // One high-rate value inside the back part; last marks the final sub-sample
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [ACC_W-1:0] data;
   } tok_type;

endpackage

// ===== hdl/ocsc_front.sv =====
module ocsc_front
   import ocsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_audio_in,
   input  logic                       queue_full,
   output sample_type                 push
);

   logic [FILTER_ORDER-1:0] valid_ff, valid_in;
   logic [ACC_W-1:0]        delay_ff [FILTER_ORDER];
   logic [ACC_W-1:0]        delay_in [FILTER_ORDER];
   logic [ACC_W-1:0]        diff_ff  [FILTER_ORDER];
   logic [ACC_W-1:0]        diff_in  [FILTER_ORDER];
   sample_type              stage_in [FILTER_ORDER];
   logic                    enable;

   // The comb chain advances as one; it only halts when its last stage holds
   // an item that the queue cannot take.
   assign enable    = !valid_ff[FILTER_ORDER-1] || !queue_full;
   assign req_ready = enable;

   always_comb begin
      stage_in[0].valid = req_valid;
      stage_in[0].data  = ACC_W'(req_audio_in);
      for (int k = 1; k < FILTER_ORDER; k++) begin
         stage_in[k].valid = valid_ff[k-1];
         stage_in[k].data  = diff_ff[k-1];
      end
      for (int k = 0; k < FILTER_ORDER; k++) begin
         valid_in[k] = enable ? stage_in[k].valid : valid_ff[k];
         delay_in[k] = delay_ff[k];
         diff_in[k]  = diff_ff[k];
         if (enable && stage_in[k].valid) begin
            delay_in[k] = stage_in[k].data;
            diff_in[k]  = stage_in[k].data - delay_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int k = 0; k < FILTER_ORDER; k++) begin
            delay_ff[k] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         delay_ff <= delay_in;
      end
      diff_ff <= diff_in;
   end

   assign push.valid = valid_ff[FILTER_ORDER-1] && enable;
   assign push.data  = diff_ff[FILTER_ORDER-1];

endmodule

// ===== hdl/ocsc_queue.sv =====
module ocsc_queue
   import ocsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  sample_type push,
   output logic       full,
   input  logic       pop,
   output sample_type head
);

   logic [ACC_W-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// ===== hdl/ocsc_clip.sv =====
module ocsc_clip
   import ocsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    enable,
   input  tok_type in_tok,
   output tok_type out_tok
);

   // Stage A: scaling, sign and magnitude, region decode
   logic                  a_valid_ff, a_valid_in;
   logic                  a_last_ff, a_last_in;
   logic                  a_neg_ff, a_neg_in;
   clip_region_type       a_region_ff, a_region_in;
   logic [MAG_W-1:0]      a_mag_ff, a_mag_in;
   logic signed [ACC_W-1:0] scaled;
   logic [ACC_W-1:0]      mag_full;

   // Stage B: square of the magnitude
   logic                  b_valid_ff, b_valid_in;
   logic                  b_last_ff, b_last_in;
   logic                  b_neg_ff, b_neg_in;
   clip_region_type       b_region_ff, b_region_in;
   logic [MAG_W-1:0]      b_mag_ff, b_mag_in;
   logic [2*MAG_W-1:0]    b_sq_ff, b_sq_in;

   // Stage C: curve evaluation and sign
   logic                  c_valid_ff, c_valid_in;
   logic                  c_last_ff, c_last_in;
   logic [ACC_W-1:0]      c_y_ff, c_y_in;
   logic [ACC_W-1:0]      pos;
   logic [ACC_W-1:0]      sq_triple;

   always_comb begin
      scaled   = $signed(in_tok.data) >>> CLIP_SHIFT;
      a_neg_in = scaled[ACC_W-1];
      mag_full = a_neg_in ? ACC_W'(0) - ACC_W'(scaled) : ACC_W'(scaled);
      if (mag_full < ACC_W'(CLIP_KNEE_LO)) begin
         a_region_in = REGION_LOW;
      end else if (mag_full < ACC_W'(CLIP_KNEE_HI)) begin
         a_region_in = REGION_MID;
      end else begin
         a_region_in = REGION_SAT;
      end
      a_mag_in   = mag_full[MAG_W-1:0];
      a_last_in  = in_tok.last;
      a_valid_in = enable ? in_tok.valid : a_valid_ff;
   end

   always_comb begin
      b_sq_in     = a_mag_ff * a_mag_ff;
      b_mag_in    = a_mag_ff;
      b_neg_in    = a_neg_ff;
      b_region_in = a_region_ff;
      b_last_in   = a_last_ff;
      b_valid_in  = enable ? a_valid_ff : b_valid_ff;
   end

   always_comb begin
      sq_triple = ACC_W'(b_sq_ff) + (ACC_W'(b_sq_ff) << 1);
      unique case (b_region_ff)
         REGION_LOW: pos = ACC_W'(b_mag_ff) << 1;
         REGION_MID: pos = (ACC_W'(b_mag_ff) << 2) - ACC_W'(CLIP_OFFSET)
                           - (sq_triple >> CLIP_SCALE_LOG2);
         REGION_SAT: pos = ACC_W'(CLIP_MAX);
         default:    pos = '0;
      endcase
      c_y_in     = b_neg_ff ? ACC_W'(0) - pos : pos;
      c_last_in  = b_last_ff;
      c_valid_in = enable ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_tok.valid) begin
         a_neg_ff    <= a_neg_in;
         a_region_ff <= a_region_in;
         a_mag_ff    <= a_mag_in;
         a_last_ff   <= a_last_in;
      end
      if (enable && a_valid_ff) begin
         b_sq_ff     <= b_sq_in;
         b_mag_ff    <= b_mag_in;
         b_neg_ff    <= b_neg_in;
         b_region_ff <= b_region_in;
         b_last_ff   <= b_last_in;
      end
      if (enable && b_valid_ff) begin
         c_y_ff    <= c_y_in;
         c_last_ff <= c_last_in;
      end
   end

   assign out_tok.valid = c_valid_ff;
   assign out_tok.last  = c_last_ff;
   assign out_tok.data  = c_y_ff;

endmodule

// ===== hdl/ocsc_back.sv =====
module ocsc_back
   import ocsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  sample_type                 head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_audio_out
);

   logic                    enable;
   logic [RATE_LOG2-1:0]    sub_ff, sub_in;
   tok_type                 src_tok;

   // Interpolator integrators
   tok_type                 up_tok [FILTER_ORDER];
   logic [FILTER_ORDER-1:0] up_valid_ff, up_valid_in;
   logic [FILTER_ORDER-1:0] up_last_ff, up_last_in;
   logic [ACC_W-1:0]        up_acc_ff [FILTER_ORDER];
   logic [ACC_W-1:0]        up_acc_in [FILTER_ORDER];

   // Clipper
   tok_type                 clip_in_tok, clip_out_tok;

   // Decimator integrators
   tok_type                 dn_tok [FILTER_ORDER];
   logic [FILTER_ORDER-1:0] dn_valid_ff, dn_valid_in;
   logic [FILTER_ORDER-1:0] dn_last_ff, dn_last_in;
   logic [ACC_W-1:0]        dn_acc_ff [FILTER_ORDER];
   logic [ACC_W-1:0]        dn_acc_in [FILTER_ORDER];

   // Decimator combs
   sample_type              cb_in [FILTER_ORDER];
   logic [FILTER_ORDER-1:0] cb_valid_ff, cb_valid_in;
   logic [ACC_W-1:0]        cb_delay_ff [FILTER_ORDER];
   logic [ACC_W-1:0]        cb_delay_in [FILTER_ORDER];
   logic [ACC_W-1:0]        cb_diff_ff  [FILTER_ORDER];
   logic [ACC_W-1:0]        cb_diff_in  [FILTER_ORDER];

   // Output register
   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]     out_data_ff, out_data_in;
   logic signed [ACC_W-1:0] out_scaled;

   // The whole back pipeline moves together and holds only while a result
   // waits in the output register and is not being taken.
   assign enable = !out_valid_ff || rsp_ready;

   // Sub-sample source: the comb output first, then zeros.
   always_comb begin
      src_tok.valid = (sub_ff != '0) || head.valid;
      src_tok.last  = (sub_ff == RATE_LOG2'(SUB_COUNT - 1));
      src_tok.data  = (sub_ff == '0) ? head.data : '0;
      pop           = enable && head.valid && (sub_ff == '0);
      sub_in        = (enable && src_tok.valid) ? sub_ff + 1'b1 : sub_ff;
   end

   always_comb begin
      up_tok[0] = src_tok;
      for (int k = 1; k < FILTER_ORDER; k++) begin
         up_tok[k].valid = up_valid_ff[k-1];
         up_tok[k].last  = up_last_ff[k-1];
         up_tok[k].data  = up_acc_ff[k-1];
      end
      for (int k = 0; k < FILTER_ORDER; k++) begin
         up_valid_in[k] = enable ? up_tok[k].valid : up_valid_ff[k];
         up_last_in[k]  = up_last_ff[k];
         up_acc_in[k]   = up_acc_ff[k];
         if (enable && up_tok[k].valid) begin
            up_last_in[k] = up_tok[k].last;
            up_acc_in[k]  = up_acc_ff[k] + up_tok[k].data;
         end
      end
   end

   assign clip_in_tok.valid = up_valid_ff[FILTER_ORDER-1];
   assign clip_in_tok.last  = up_last_ff[FILTER_ORDER-1];
   assign clip_in_tok.data  = up_acc_ff[FILTER_ORDER-1];

   ocsc_clip u_clip (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .in_tok  (clip_in_tok),
      .out_tok (clip_out_tok)
   );

   always_comb begin
      dn_tok[0] = clip_out_tok;
      for (int k = 1; k < FILTER_ORDER; k++) begin
         dn_tok[k].valid = dn_valid_ff[k-1];
         dn_tok[k].last  = dn_last_ff[k-1];
         dn_tok[k].data  = dn_acc_ff[k-1];
      end
      for (int k = 0; k < FILTER_ORDER; k++) begin
         dn_valid_in[k] = enable ? dn_tok[k].valid : dn_valid_ff[k];
         dn_last_in[k]  = dn_last_ff[k];
         dn_acc_in[k]   = dn_acc_ff[k];
         if (enable && dn_tok[k].valid) begin
            dn_last_in[k] = dn_tok[k].last;
            dn_acc_in[k]  = dn_acc_ff[k] + dn_tok[k].data;
         end
      end
   end

   // Only the last sub-sample of each item enters the combs.
   always_comb begin
      cb_in[0].valid = dn_valid_ff[FILTER_ORDER-1] && dn_last_ff[FILTER_ORDER-1];
      cb_in[0].data  = dn_acc_ff[FILTER_ORDER-1];
      for (int k = 1; k < FILTER_ORDER; k++) begin
         cb_in[k].valid = cb_valid_ff[k-1];
         cb_in[k].data  = cb_diff_ff[k-1];
      end
      for (int k = 0; k < FILTER_ORDER; k++) begin
         cb_valid_in[k] = enable ? cb_in[k].valid : cb_valid_ff[k];
         cb_delay_in[k] = cb_delay_ff[k];
         cb_diff_in[k]  = cb_diff_ff[k];
         if (enable && cb_in[k].valid) begin
            cb_delay_in[k] = cb_in[k].data;
            cb_diff_in[k]  = cb_in[k].data - cb_delay_ff[k];
         end
      end
   end

   always_comb begin
      out_scaled   = $signed(cb_diff_ff[FILTER_ORDER-1]) >>> OUT_SHIFT;
      out_valid_in = enable ? cb_valid_ff[FILTER_ORDER-1] : out_valid_ff;
      out_data_in  = (enable && cb_valid_ff[FILTER_ORDER-1]) ?
                     out_scaled[SAMPLE_W-1:0] : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= '0;
         up_valid_ff  <= '0;
         dn_valid_ff  <= '0;
         cb_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < FILTER_ORDER; k++) begin
            up_acc_ff[k]   <= '0;
            dn_acc_ff[k]   <= '0;
            cb_delay_ff[k] <= '0;
         end
      end else begin
         sub_ff       <= sub_in;
         up_valid_ff  <= up_valid_in;
         dn_valid_ff  <= dn_valid_in;
         cb_valid_ff  <= cb_valid_in;
         out_valid_ff <= out_valid_in;
         up_acc_ff    <= up_acc_in;
         dn_acc_ff    <= dn_acc_in;
         cb_delay_ff  <= cb_delay_in;
      end
      up_last_ff  <= up_last_in;
      dn_last_ff  <= dn_last_in;
      cb_diff_ff  <= cb_diff_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_audio_out = $signed(out_data_ff);

endmodule

// ===== hdl/oversampled_cic_soft_clipper_top.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_audio_in  (signed 16 bits)
// rsp       out        rsp_valid/rsp_ready  rsp_audio_out (signed 16 bits)
//
// Each item is expanded into 2^RATE_LOG2 sub-samples (4 by default), one
// sub-sample per cycle through the up-integrators, clipper and down-integrators
// while the output does not stall the back part.
// Reset is synchronous and clears all filter state at once; no clearing pass.
// A stalled result freezes the back part; the queue then fills and the front
// part halts, dropping req_ready.
module oversampled_cic_soft_clipper_top
   import ocsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_audio_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_audio_out
);

   // Front to queue, and queue to back.
   sample_type push;
   sample_type head;
   logic       queue_full;
   logic       pop;

   // The front part accepts each item and runs the interpolator combs, one
   // comb per pipeline stage. Its last difference is the low-rate value that
   // gets zero-stuffed.
   ocsc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_audio_in (req_audio_in),
      .queue_full   (queue_full),
      .push         (push)
   );

   // A short queue lets the front part keep accepting items while the back
   // part is still expanding an earlier one or is held by the output.
   ocsc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   // The back part expands each item into its sub-samples, integrates, clips,
   // integrates again, keeps the last sub-sample and runs the decimator combs.
   ocsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_audio_out (rsp_audio_out)
   );

endmodule

// ===== dv/oversampled_cic_soft_clipper_top_tb.sv =====
// Self-checking bench for the oversampled CIC soft clipper. A driver and a
// monitor run as clocked always blocks; the driver takes items from a queue
// that the stimulus block fills, predicts each accepted item and stores the
// expected output sample, and the monitor compares every returned item with
// the oldest stored sample.
module oversampled_cic_soft_clipper_top_tb;
   import ocsc_pkg::*;

   // Once this few items remain to be sent, both sides stop idling so that
   // the end of the run goes through at full rate.
   localparam int TAIL_ITEMS   = 150;
   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_WAIT   = 64;
   localparam int MAX_PRINTS   = 40;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      bit                  drain_first;
   } audio_item_type;

   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       req_valid    = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_audio_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready    = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_audio_out;

   audio_item_type      pending_audio[$];
   logic [SAMPLE_W-1:0] expected_audio[$];

   // The predictor's own copy of the four filter delay lines.
   logic [ACC_W-1:0] up_comb_dly  [FILTER_ORDER];
   logic [ACC_W-1:0] up_integ     [FILTER_ORDER];
   logic [ACC_W-1:0] down_integ   [FILTER_ORDER];
   logic [ACC_W-1:0] down_comb_dly[FILTER_ORDER];

   int error_count = 0;
   int send_idle   = 0;
   int sink_stall  = 0;

   oversampled_cic_soft_clipper_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_audio_in  (req_audio_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_audio_out (rsp_audio_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit tail_phase();
      return pending_audio.size() < TAIL_ITEMS;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
   endtask

   // Symmetric diode curve. The magnitude is taken as an unsigned 32-bit
   // value, so the most negative input gives 2^31 and saturates cleanly.
   function automatic logic [ACC_W-1:0] diode_shape(input logic [ACC_W-1:0] x);
      logic             neg;
      logic [ACC_W-1:0] mag;
      longint           m;
      longint           y;
      neg = x[ACC_W-1];
      mag = neg ? (~x + 1'b1) : x;
      m   = {32'd0, mag};
      if (m < CLIP_KNEE_LO) begin
         y = 2 * m;
      end else if (m < CLIP_KNEE_HI) begin
         // The square term is always positive here, so division truncates
         // exactly as a floor would.
         y = -longint'(CLIP_OFFSET) + 4 * m - (3 * m * m) / (longint'(1) << CLIP_SCALE_LOG2);
      end else begin
         y = CLIP_MAX;
      end
      if (neg) begin
         y = -y;
      end
      return y[ACC_W-1:0];
   endfunction

   // Runs one low-rate sample through interpolator, clipper and decimator,
   // updating the predictor's delay lines, and returns the output sample.
   function automatic logic [SAMPLE_W-1:0] distort_sample(input logic [SAMPLE_W-1:0] sample);
      logic [ACC_W-1:0] v;
      logic [ACC_W-1:0] d;
      logic [ACC_W-1:0] s;
      logic [ACC_W-1:0] stuffed;
      logic [ACC_W-1:0] last;
      logic [ACC_W-1:0] scaled;
      v    = {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      last = '0;
      for (int i = 0; i < FILTER_ORDER; i++) begin
         d              = v - up_comb_dly[i];
         up_comb_dly[i] = v;
         v              = d;
      end
      stuffed = v;
      for (int j = 0; j < SUB_COUNT; j++) begin
         s = stuffed;
         for (int i = 0; i < FILTER_ORDER; i++) begin
            up_integ[i] = up_integ[i] + s;
            s           = up_integ[i];
         end
         // Zero stuffing: only the first sub-sample carries the comb output.
         stuffed = '0;
         scaled  = $signed(s) >>> CLIP_SHIFT;
         s       = diode_shape(scaled);
         for (int i = 0; i < FILTER_ORDER; i++) begin
            down_integ[i] = down_integ[i] + s;
            s             = down_integ[i];
         end
         last = s;
      end
      v = last;
      for (int i = 0; i < FILTER_ORDER; i++) begin
         d                = v - down_comb_dly[i];
         down_comb_dly[i] = v;
         v                = d;
      end
      scaled = $signed(v) >>> OUT_SHIFT;
      return scaled[SAMPLE_W-1:0];
   endfunction

   // Driver. An item is predicted at the edge at which it is accepted. The
   // next item is presented only once the current one has gone, so valid
   // and the payload hold steady while the block stalls. An idle burst may
   // follow any accepted item, and an item marked drain_first is held back
   // until every expected sample has come out of the block.
   always @(posedge clock) begin
      audio_item_type next_item;
      if (reset) begin
         req_valid    <= 1'b0;
         req_audio_in <= '0;
         send_idle    = 0;
         for (int i = 0; i < FILTER_ORDER; i++) begin
            up_comb_dly[i]   = '0;
            up_integ[i]      = '0;
            down_integ[i]    = '0;
            down_comb_dly[i] = '0;
         end
      end else begin
         if (req_valid && req_ready) begin
            expected_audio.push_back(distort_sample(req_audio_in));
         end
         if (!req_valid || req_ready) begin
            if (req_valid && !tail_phase() && $urandom_range(0, 4) == 0) begin
               send_idle = $urandom_range(1, 10);
            end
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (pending_audio.size() > 0 &&
                         (!pending_audio[0].drain_first || expected_audio.size() == 0)) begin
               next_item = pending_audio.pop_front();
               req_valid    <= 1'b1;
               req_audio_in <= next_item.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every returned item is checked against the oldest expected
   // sample; ready is withdrawn in random bursts until the tail of the run.
   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_audio.size() == 0) begin
               report_mismatch($sformatf("output item %0d with none expected",
                                         $signed(rsp_audio_out)));
            end else begin
               want = expected_audio.pop_front();
               if (rsp_audio_out !== want) begin
                  report_mismatch($sformatf("audio_out got %0d expected %0d",
                                            $signed(rsp_audio_out), $signed(want)));
               end
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_ready <= 1'b0;
         end else if (!tail_phase() && $urandom_range(0, 11) == 0) begin
            sink_stall = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_sample(input int value, input bit drain = 1'b0);
      audio_item_type item;
      item.sample      = value[SAMPLE_W-1:0];
      item.drain_first = drain;
      pending_audio.push_back(item);
   endtask

   // Random sequences: plain noise, steady levels that settle the filters
   // into one region of the clipper, full-scale swings that overshoot the
   // interpolator and wrap the integrators, small signals around zero and
   // ramps that sweep through the knees of the curve.
   task automatic queue_random_audio();
      int count;
      int level;
      int step;
      int mode;
      int run;
      count = 0;
      while (count < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 4);
         run  = 0;
         case (mode)
            0: begin
               run = $urandom_range(1, 30);
               for (int k = 0; k < run; k++) begin
                  queue_sample($urandom_range(0, 65535));
               end
            end
            1: begin
               run   = $urandom_range(4, 40);
               level = $urandom_range(0, 65535) - 32768;
               for (int k = 0; k < run; k++) begin
                  queue_sample(level);
               end
            end
            2: begin
               run = $urandom_range(2, 12);
               for (int k = 0; k < run; k++) begin
                  level = $urandom_range(28000, 32767);
                  queue_sample((k % 2 == 0) ? level : -level - 1);
               end
            end
            3: begin
               run = $urandom_range(4, 30);
               for (int k = 0; k < run; k++) begin
                  queue_sample($urandom_range(0, 400) - 200);
               end
            end
            default: begin
               run   = $urandom_range(8, 40);
               level = $urandom_range(0, 65535) - 32768;
               step  = $urandom_range(0, 4000) - 2000;
               for (int k = 0; k < run; k++) begin
                  queue_sample(level + k * step);
               end
            end
         endcase
         count += run;
         // Partway through, the sender waits for the block to empty once.
         if (count >= RANDOM_ITEMS / 2 && count - run < RANDOM_ITEMS / 2) begin
            queue_sample($urandom_range(0, 65535), 1'b1);
            count++;
         end
      end
   endtask

   initial begin
      // Directed part: silence, steady full scale of both signs (saturation),
      // alternating full-scale swings for the largest overshoot and the most
      // negative clipper input, then levels in the doubling and the
      // quadratic region, and the smallest values either side of zero.
      queue_sample(0);
      queue_sample(0);
      for (int k = 0; k < 4; k++) queue_sample(32767);
      for (int k = 0; k < 4; k++) queue_sample(-32768);
      for (int k = 0; k < 4; k++) queue_sample((k % 2 == 0) ? 32767 : -32768);
      for (int k = 0; k < 3; k++) queue_sample(5000);
      for (int k = 0; k < 3; k++) queue_sample(15000);
      queue_sample(-15000);
      queue_sample(-15000);
      queue_sample(1);
      queue_sample(-1, 1'b1);
      queue_random_audio();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_audio.size() != 0 || req_valid) @(posedge clock);
      while (expected_audio.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
